/* hw/rtl/lcm3_pkg.sv */
// Shared constants, state types and interface structs for the three-operand LCM block.
package lcm3_pkg;

	localparam int unsigned OPERAND_BITS = 16;
	localparam int unsigned PAIR_BITS    = 2 * OPERAND_BITS;
	localparam int unsigned RESULT_BITS  = 3 * OPERAND_BITS;
	localparam int unsigned SHIFT_BITS   = $clog2(PAIR_BITS);

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_GCD,
		ENG_DIV,
		ENG_MUL,
		ENG_DONE
	} eng_state_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_PAIR1,
		TOP_PAIR2,
		TOP_OUT
	} top_state_t;

	typedef struct packed {
		logic [RESULT_BITS-1:0] a;
		logic [RESULT_BITS-1:0] b;
		logic                   sub;
	} unit_req_t;

	typedef struct packed {
		logic [RESULT_BITS-1:0] sum;
		logic                   borrow;
	} unit_rsp_t;

	typedef struct packed {
		logic start;
	} eng_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_sts_t;

endpackage

/* hw/rtl/lcm3_addsub.sv */
// Shared adder/subtractor used by the GCD, division and multiply steps of the pair LCM engine.
module lcm3_addsub (
	input  lcm3_pkg::unit_req_t req,
	output lcm3_pkg::unit_rsp_t rsp
);

	logic [lcm3_pkg::RESULT_BITS:0] full;
	logic [lcm3_pkg::RESULT_BITS-1:0] b_eff;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign full  = {1'b0, req.a} + {1'b0, b_eff}
		+ {{lcm3_pkg::RESULT_BITS{1'b0}}, req.sub};

	// A subtraction borrows when there is no carry out of the top bit.
	assign rsp.sum    = full[lcm3_pkg::RESULT_BITS-1:0];
	assign rsp.borrow = req.sub & ~full[lcm3_pkg::RESULT_BITS];

endmodule

/* hw/rtl/lcm3_engine.sv */
// Pair LCM engine: binary GCD, restoring division and shift-add multiply on one shared unit.
module lcm3_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lcm3_pkg::eng_ctl_t                  ctl,
	input  logic [lcm3_pkg::PAIR_BITS-1:0]      x_in,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   y_in,
	output lcm3_pkg::eng_sts_t                  sts,
	output logic [lcm3_pkg::RESULT_BITS-1:0]    result
);

	localparam int unsigned PW = lcm3_pkg::PAIR_BITS;
	localparam int unsigned RW = lcm3_pkg::RESULT_BITS;
	localparam int unsigned OW = lcm3_pkg::OPERAND_BITS;
	localparam int unsigned KW = lcm3_pkg::SHIFT_BITS;

	lcm3_pkg::eng_state_t state_q, state_d;
	lcm3_pkg::unit_req_t  req;
	lcm3_pkg::unit_rsp_t  rsp;

	logic [PW-1:0] x_q, y_q, xsave_q, num_q, div_q, rem_q;
	logic [KW-1:0] k_q, cnt_q;
	logic [OW-1:0] ysave_q, mult_q;
	logic [RW-1:0] acc_q, mcand_q;
	logic [PW:0]   sh;
	logic          gcd_equal, div_last;

	assign gcd_equal = (x_q == y_q);
	assign div_last  = (cnt_q == KW'(PW - 1));
	assign sh        = {rem_q, num_q[PW-1]};

	lcm3_addsub u_unit (
		.req (req),
		.rsp (rsp)
	);

	always_comb begin
		req = '0;
		case (state_q)
			lcm3_pkg::ENG_GCD: begin
				req.a   = RW'(x_q);
				req.b   = RW'(y_q);
				req.sub = 1'b1;
			end
			lcm3_pkg::ENG_DIV: begin
				req.a   = RW'(sh);
				req.b   = RW'(div_q);
				req.sub = 1'b1;
			end
			lcm3_pkg::ENG_MUL: begin
				req.a   = acc_q;
				req.b   = mcand_q;
				req.sub = 1'b0;
			end
			default: req = '0;
		endcase
	end

	// A new pair may start in the done cycle, while the previous result is still shown.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcm3_pkg::ENG_IDLE: if (ctl.start) state_d = lcm3_pkg::ENG_GCD;
			lcm3_pkg::ENG_GCD:  if (gcd_equal) state_d = lcm3_pkg::ENG_DIV;
			lcm3_pkg::ENG_DIV:  if (div_last) state_d = lcm3_pkg::ENG_MUL;
			lcm3_pkg::ENG_MUL:  if (mult_q == '0) state_d = lcm3_pkg::ENG_DONE;
			lcm3_pkg::ENG_DONE: state_d = ctl.start ? lcm3_pkg::ENG_GCD : lcm3_pkg::ENG_IDLE;
			default:            state_d = lcm3_pkg::ENG_IDLE;
		endcase
	end

	always_comb begin
		sts.busy = (state_q != lcm3_pkg::ENG_IDLE);
		sts.done = (state_q == lcm3_pkg::ENG_DONE);
	end

	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcm3_pkg::ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			lcm3_pkg::ENG_IDLE, lcm3_pkg::ENG_DONE: begin
				if (ctl.start) begin
					x_q     <= x_in;
					y_q     <= PW'(y_in);
					xsave_q <= x_in;
					ysave_q <= y_in;
					k_q     <= '0;
				end
			end
			lcm3_pkg::ENG_GCD: begin
				if (gcd_equal) begin
					// The common power of two is restored before dividing.
					div_q <= x_q << k_q;
					num_q <= xsave_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + KW'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (rsp.borrow) begin
					// Both odd and x smaller: swap so the next step subtracts.
					x_q <= y_q;
					y_q <= x_q;
				end else begin
					x_q <= rsp.sum[PW-1:0];
				end
			end
			lcm3_pkg::ENG_DIV: begin
				if (rsp.borrow) begin
					rem_q <= sh[PW-1:0];
				end else begin
					rem_q <= rsp.sum[PW-1:0];
				end
				num_q <= {num_q[PW-2:0], ~rsp.borrow};
				cnt_q <= cnt_q + KW'(1);
				if (div_last) begin
					acc_q   <= '0;
					mcand_q <= RW'({num_q[PW-2:0], ~rsp.borrow});
					mult_q  <= ysave_q;
				end
			end
			lcm3_pkg::ENG_MUL: begin
				if (mult_q != '0) begin
					if (mult_q[0]) acc_q <= rsp.sum;
					mcand_q <= mcand_q << 1;
					mult_q  <= mult_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/lcm_of_three.sv */
// Top level of the three-operand least common multiple block.
// Each word carries three unsigned operands and yields one exact result,
// lcm(lcm(a, b), c), in 3*OPERAND_BITS bits; a zero operand gives zero
// and skips the engine, going straight to the output register once that
// is free. Otherwise the word runs twice through one pair LCM engine,
// which does all of its work on a single shared adder/subtractor: a binary
// GCD (one shift, swap or subtract per cycle), a restoring division, a
// shift-add multiply and a done state, in which the second pair already
// starts. The result then passes through a holding register to the output
// register. The input stalls while a word is in work; the finished result
// sits in an output register, so the next word is taken while it waits to
// be read.
module lcm_of_three (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   first_operand,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   second_operand,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   third_operand,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lcm3_pkg::RESULT_BITS-1:0]    lcm_value
);

	localparam int unsigned PW = lcm3_pkg::PAIR_BITS;
	localparam int unsigned RW = lcm3_pkg::RESULT_BITS;
	localparam int unsigned OW = lcm3_pkg::OPERAND_BITS;

	lcm3_pkg::top_state_t state_q, state_d;
	lcm3_pkg::eng_ctl_t   eng_ctl;
	lcm3_pkg::eng_sts_t   eng_sts;

	logic [PW-1:0] eng_x;
	logic [OW-1:0] eng_y, c_q;
	logic [RW-1:0] eng_result, res_q, out_q;
	logic          out_valid_q, any_zero, out_free, accept, load_out;

	assign any_zero = (first_operand == '0) || (second_operand == '0)
		|| (third_operand == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;

	lcm3_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eng_ctl),
		.x_in   (eng_x),
		.y_in   (eng_y),
		.sts    (eng_sts),
		.result (eng_result)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcm3_pkg::TOP_IDLE: begin
				if (in_valid) begin
					state_d = any_zero ? lcm3_pkg::TOP_OUT : lcm3_pkg::TOP_PAIR1;
				end
			end
			lcm3_pkg::TOP_PAIR1: if (eng_sts.done) state_d = lcm3_pkg::TOP_PAIR2;
			lcm3_pkg::TOP_PAIR2: if (eng_sts.done) state_d = lcm3_pkg::TOP_OUT;
			lcm3_pkg::TOP_OUT:   if (out_free) state_d = lcm3_pkg::TOP_IDLE;
			default:             state_d = lcm3_pkg::TOP_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		eng_ctl.start = 1'b0;
		eng_x         = eng_result[PW-1:0];
		eng_y         = c_q;
		load_out      = 1'b0;
		unique case (state_q)
			lcm3_pkg::TOP_IDLE: begin
				in_stall      = 1'b0;
				eng_ctl.start = in_valid && !any_zero;
				eng_x         = PW'(first_operand);
				eng_y         = second_operand;
			end
			lcm3_pkg::TOP_PAIR1: eng_ctl.start = eng_sts.done;
			lcm3_pkg::TOP_PAIR2: begin
			end
			lcm3_pkg::TOP_OUT:   load_out = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcm3_pkg::TOP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q   <= third_operand;
			res_q <= '0;
		end
		if (state_q == lcm3_pkg::TOP_PAIR2 && eng_sts.done) begin
			res_q <= eng_result;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign lcm_value = out_q;

endmodule

/* hw/rtl/lcm3_checker.sv */
// Port-level checker for the three-operand LCM block, bound to the top level.
module lcm3_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [lcm3_pkg::RESULT_BITS-1:0]    lcm_value
);

	// A result waiting to be read stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(lcm_value))
		else $error("result word changed while stalled");

	// The block works on one word at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while the first is in work");

	// No result can appear in the cycle right after a word is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result word appeared too early");

endmodule

bind lcm_of_three lcm3_checker u_lcm3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.lcm_value (lcm_value)
);

/* tb/lcm_checker.sv */
`timescale 1ns / 1ps
// Watches both channels of the LCM block, predicts each result and compares it.
module lcm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   first_operand,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   second_operand,
	input  logic [lcm3_pkg::OPERAND_BITS-1:0]   third_operand,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [lcm3_pkg::RESULT_BITS-1:0]    lcm_value,
	output int unsigned                         pending_results,
	output int unsigned                         fail_count
);

	logic [lcm3_pkg::RESULT_BITS-1:0] expected_lcm [$];
	int unsigned                      mismatches  = 0;
	int unsigned                      outstanding = 0;

	assign pending_results = outstanding;
	assign fail_count      = mismatches;

	function automatic longint unsigned greatest_divisor(input longint unsigned x,
		input longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// A zero operand makes the whole multiple zero.
	function automatic longint unsigned pair_multiple(input longint unsigned x,
		input longint unsigned y);
		if (x == 0 || y == 0) begin
			return 0;
		end
		return (x / greatest_divisor(x, y)) * y;
	endfunction

	always @(posedge clk) begin
		longint unsigned                  lcm_full;
		logic [lcm3_pkg::RESULT_BITS-1:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				lcm_full = pair_multiple(pair_multiple(64'(first_operand),
					64'(second_operand)), 64'(third_operand));
				expected_lcm.push_back(lcm_full[lcm3_pkg::RESULT_BITS-1:0]);
			end
			if (out_valid && !out_stall) begin
				if (expected_lcm.size() == 0) begin
					$error("lcm_value: no word expected, got %0d", lcm_value);
					mismatches++;
				end else begin
					want = expected_lcm.pop_front();
					if (lcm_value !== want) begin
						$error("lcm_value mismatch: expected %0d, actual %0d", want, lcm_value);
						mismatches++;
					end
				end
			end
			outstanding = expected_lcm.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the three-operand LCM block: clock, reset, stimulus and verdict.
module tb;

	localparam int unsigned OPND_BITS    = lcm3_pkg::OPERAND_BITS;
	localparam int unsigned RES_BITS     = lcm3_pkg::RESULT_BITS;
	localparam int unsigned RANDOM_WORDS = 1880;
	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned DRAIN_CYCLES = 320;
	localparam logic [OPND_BITS-1:0] OPND_MAX = '1;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   in_valid       = 1'b0;
	logic                   in_stall;
	logic [OPND_BITS-1:0]   first_operand  = '0;
	logic [OPND_BITS-1:0]   second_operand = '0;
	logic [OPND_BITS-1:0]   third_operand  = '0;
	logic                   out_valid;
	logic                   out_stall      = 1'b0;
	logic [RES_BITS-1:0]    lcm_value;

	int unsigned send_idle_pct  = 29;
	int unsigned recv_stall_pct = 49;
	int unsigned quiet_cycles   = 0;
	int unsigned pending_results;
	int unsigned fail_count;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	lcm_of_three u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.third_operand  (third_operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.lcm_value      (lcm_value)
	);

	lcm_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.first_operand   (first_operand),
		.second_operand  (second_operand),
		.third_operand   (third_operand),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.lcm_value       (lcm_value),
		.pending_results (pending_results),
		.fail_count      (fail_count)
	);

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// The run is stuck if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles == STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [OPND_BITS-1:0] a,
		input logic [OPND_BITS-1:0] b, input logic [OPND_BITS-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		first_operand  <= a;
		second_operand <= b;
		third_operand  <= c;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Many triples share a common factor so that the GCD steps do real work.
	task automatic send_random_word();
		logic [OPND_BITS-1:0] opnd [3];
		int unsigned          kind;
		int unsigned          base;
		kind = $urandom_range(9);
		base = $urandom_range(1, 255);
		for (int i = 0; i < 3; i++) begin
			case (kind)
				0, 1, 2: begin
					opnd[i] = OPND_BITS'($urandom_range(1, OPND_MAX));
				end
				3, 4, 5: begin
					opnd[i] = OPND_BITS'(base * $urandom_range(1, OPND_MAX / base));
				end
				6: begin
					opnd[i] = OPND_BITS'($urandom_range(1, 64));
				end
				7: begin
					opnd[i] = {{(OPND_BITS-1){1'b0}}, 1'b1} << $urandom_range(OPND_BITS-1);
				end
				8: begin
					opnd[i] = OPND_BITS'(OPND_MAX - $urandom_range(3));
				end
				default: begin
					opnd[i] = ($urandom_range(19) == 0) ? '0
						: OPND_BITS'($urandom_range(1, OPND_MAX));
				end
			endcase
		end
		send_word(opnd[0], opnd[1], opnd[2]);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(1, 1, 1);
		send_word(OPND_MAX, OPND_MAX, OPND_MAX);
		send_word(65535, 65534, 65533);
		send_word(65521, 65519, 65497);
		send_word(1, OPND_MAX, 1);
		send_word(0, 5, 7);
		send_word(5, 0, 7);
		send_word(5, 7, 0);
		send_word(0, 0, 0);
		send_word(32768, 16384, 1);
		send_word(16'h5555, 16'hAAAA, 16'hFFFF);
		send_word(16'hAAAA, 16'h5555, 16'h8000);
		send_word(2, 3, 5);
		send_word(12, 18, 30);
		send_word(1024, 768, 65535);
		send_word(OPND_MAX, 1, 16'h8000);
		send_word(7, 7, 7);
		send_word(4096, 4096, 8192);
		send_word(46341, 46340, 46339);
		send_word(65536 / 2 - 1, 65535 - 2, 1);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 29;
					recv_stall_pct = 49;
				end
				1: begin
					send_idle_pct  = 49;
					recv_stall_pct = 29;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (RANDOM_WORDS / 3) send_random_word();
		end

		in_valid <= 1'b0;
		wait (pending_results == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
